@@ hw/rtl/ifbs_pkg.sv @@
package ifbs_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SELECT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    RK_READ  = 2'd0,
    RK_GRANT = 2'd1,
    RK_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_WRITE_FULL = 3'd1,
    ERR_READ_EMPTY = 3'd2,
    ERR_ZERO_MASK  = 3'd3,
    ERR_PENDING    = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_READ   = 2'd1,
    ST_SEARCH = 2'd2
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic set_pending;
    logic grant;
    logic emit_read;
    logic emit_err;
    err_t err;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic mask_zero;
    logic pending;
  } stat_t;

endpackage

@@ hw/rtl/ifbs_ctrl.sv @@
module ifbs_ctrl
  import ifbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_command,
  input  stat_t      stat,
  output ctl_t       ctl,
  output logic       busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_command)
            CMD_WRITE: begin
              if (!stat.full) state_nxt = ST_SEARCH;
            end
            CMD_READ: begin
              if (!stat.empty) state_nxt = ST_READ;
            end
            CMD_SELECT: begin
              if (!stat.mask_zero && !stat.pending) state_nxt = ST_SEARCH;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ:   state_nxt = ST_IDLE;
      ST_SEARCH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.err = ERR_NONE;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_command)
            CMD_WRITE: begin
              if (stat.full) begin
                ctl.emit_err = 1'b1;
                ctl.err = ERR_WRITE_FULL;
              end else begin
                ctl.push = 1'b1;
              end
            end
            CMD_READ: begin
              if (stat.empty) begin
                ctl.emit_err = 1'b1;
                ctl.err = ERR_READ_EMPTY;
              end else begin
                ctl.pop = 1'b1;
              end
            end
            CMD_SELECT: begin
              if (stat.mask_zero) begin
                ctl.emit_err = 1'b1;
                ctl.err = ERR_ZERO_MASK;
              end else if (stat.pending) begin
                ctl.emit_err = 1'b1;
                ctl.err = ERR_PENDING;
              end else begin
                ctl.set_pending = 1'b1;
              end
            end
            default: ctl.emit_err = 1'b0;
          endcase
        end
      end
      ST_READ:   ctl.emit_read = 1'b1;
      ST_SEARCH: ctl.grant = 1'b1;
      default:   ctl.emit_err = 1'b0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  a_read_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> $past(ctl.pop))
    else $error("read state without pop");

  a_search_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH |-> $past(ctl.push || ctl.set_pending))
    else $error("search without push or select");

  a_no_accept_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !(ctl.push || ctl.pop || ctl.set_pending || ctl.emit_err))
    else $error("item decoded while busy");

endmodule

@@ hw/rtl/ifbs_datapath.sv @@
module ifbs_datapath
  import ifbs_pkg::*;
#(
  parameter int NUM_FIFOS  = 4,
  parameter int FIFO_DEPTH = 4,
  parameter int WORD_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_t        ctl,
  input  logic [1:0]  in_fifo_index,
  input  logic [31:0] in_write_data,
  input  logic [3:0]  in_channel_mask,
  output stat_t       stat,
  output logic        out_strobe,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_read_data,
  output logic [1:0]  out_granted_channel,
  output logic [2:0]  out_error_code
);

  localparam int CW   = (NUM_FIFOS > 1) ? $clog2(NUM_FIFOS) : 1;
  localparam int PW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNTW = $clog2(FIFO_DEPTH + 1);

  logic [WORD_BITS-1:0] mem [NUM_FIFOS][FIFO_DEPTH];
  logic [WORD_BITS-1:0] rd_q_r;

  logic [PW-1:0]   head_r [NUM_FIFOS];
  logic [PW-1:0]   tail_r [NUM_FIFOS];
  logic [CNTW-1:0] fill_r [NUM_FIFOS];
  logic [CW-1:0]   last_r;
  logic [NUM_FIFOS-1:0] pending_r;

  logic        out_strobe_r;
  logic [1:0]  out_kind_r;
  logic [31:0] out_data_r;
  logic [1:0]  out_chan_r;
  logic [2:0]  out_err_r;

  logic                 idx_ok;
  logic [CW-1:0]        idx;
  logic [NUM_FIFOS-1:0] mask_v;
  logic [NUM_FIFOS-1:0] req;
  logic                 found;
  logic [CW-1:0]        found_ch;
  logic [CW:0]          sum;

  assign idx_ok = (32'(in_fifo_index) < NUM_FIFOS);
  assign idx    = CW'(in_fifo_index);

  always_comb begin
    for (int c = 0; c < NUM_FIFOS; c++) begin
      mask_v[c] = (c < 4) ? in_channel_mask[c % 4] : 1'b0;
      req[c]    = pending_r[c] && (fill_r[c] != '0);
    end
  end

  always_comb begin
    stat.full      = !idx_ok || (fill_r[idx] == CNTW'(FIFO_DEPTH));
    stat.empty     = !idx_ok || (fill_r[idx] == '0);
    stat.mask_zero = (mask_v == '0);
    stat.pending   = (pending_r != '0);
  end

  // round-robin: lowest offset after last_r wins
  always_comb begin
    found    = 1'b0;
    found_ch = '0;
    sum      = '0;
    for (int k = NUM_FIFOS; k >= 1; k--) begin
      sum = {1'b0, last_r} + (CW+1)'(k);
      if (sum >= (CW+1)'(NUM_FIFOS)) sum = sum - (CW+1)'(NUM_FIFOS);
      if (req[sum[CW-1:0]]) begin
        found    = 1'b1;
        found_ch = sum[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) mem[idx][tail_r[idx]] <= WORD_BITS'(in_write_data);
    if (ctl.pop)  rd_q_r <= mem[idx][head_r[idx]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_FIFOS; c++) begin
        head_r[c] <= '0;
        tail_r[c] <= '0;
        fill_r[c] <= '0;
      end
      last_r    <= '0;
      pending_r <= '0;
    end else begin
      if (ctl.push) begin
        tail_r[idx] <= (tail_r[idx] == PW'(FIFO_DEPTH - 1)) ? '0 : tail_r[idx] + 1'b1;
        fill_r[idx] <= fill_r[idx] + 1'b1;
      end
      if (ctl.pop) begin
        head_r[idx] <= (head_r[idx] == PW'(FIFO_DEPTH - 1)) ? '0 : head_r[idx] + 1'b1;
        fill_r[idx] <= fill_r[idx] - 1'b1;
      end
      if (ctl.set_pending) pending_r <= mask_v;
      if (ctl.grant && found) begin
        last_r    <= found_ch;
        pending_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctl.emit_err || ctl.emit_read || (ctl.grant && found);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_err) begin
      out_kind_r <= RK_ERROR;
      out_data_r <= '0;
      out_chan_r <= '0;
      out_err_r  <= ctl.err;
    end else if (ctl.emit_read) begin
      out_kind_r <= RK_READ;
      out_data_r <= 32'(rd_q_r);
      out_chan_r <= '0;
      out_err_r  <= ERR_NONE;
    end else if (ctl.grant && found) begin
      out_kind_r <= RK_GRANT;
      out_data_r <= '0;
      out_chan_r <= 2'(found_ch);
      out_err_r  <= ERR_NONE;
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_result_kind     = out_kind_r;
  assign out_read_data       = out_data_r;
  assign out_granted_channel = out_chan_r;
  assign out_error_code      = out_err_r;

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> !stat.empty)
    else $error("pop of empty fifo");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !stat.full)
    else $error("push into full fifo");

  a_grant_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.grant && found) |=> (pending_r == '0) && out_strobe_r
      && (out_kind_r == RK_GRANT))
    else $error("grant did not clear pending select");

endmodule

@@ hw/rtl/input_fifo_bank_select_ready.sv @@
// Channel   Ports                                           Handshake
// in        in_command in_fifo_index in_write_data          start, busy
//           in_channel_mask
// out       out_result_kind out_read_data                   out_strobe
//           out_granted_channel out_error_code
//
// Error results show the cycle after start; unused commands give no result.
// Reads pass the registered read port of the word memory and then the output
// register. Good writes and good selects run the round-robin search after the
// pointer update and give a grant only when it finds a channel. busy is high
// in the read and search states. Synchronous active-low reset clears pointers,
// counts and any pending select; no clearing pass. Results are never stalled.
module input_fifo_bank_select_ready
  import ifbs_pkg::*;
#(
  parameter int NUM_FIFOS  = 4,
  parameter int FIFO_DEPTH = 4,
  parameter int WORD_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [1:0]  in_fifo_index,
  input  logic [31:0] in_write_data,
  input  logic [3:0]  in_channel_mask,
  output logic        out_strobe,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_read_data,
  output logic [1:0]  out_granted_channel,
  output logic [2:0]  out_error_code
);

  ctl_t  ctl;
  stat_t stat;

  ifbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .ctl        (ctl),
    .busy       (busy)
  );

  ifbs_datapath #(
    .NUM_FIFOS  (NUM_FIFOS),
    .FIFO_DEPTH (FIFO_DEPTH),
    .WORD_BITS  (WORD_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .in_fifo_index       (in_fifo_index),
    .in_write_data       (in_write_data),
    .in_channel_mask     (in_channel_mask),
    .stat                (stat),
    .out_strobe          (out_strobe),
    .out_result_kind     (out_result_kind),
    .out_read_data       (out_read_data),
    .out_granted_channel (out_granted_channel),
    .out_error_code      (out_error_code)
  );

endmodule

@@ dv/tb_input_fifo_bank_select_ready.sv @@
module tb_input_fifo_bank_select_ready;
  timeunit 1ns;
  timeprecision 1ps;

  import ifbs_pkg::*;

  localparam int CHANS = 4;
  localparam int DEPTH = 4;
  localparam int RANDOM_ITEMS = 800;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [1:0]  idx;
    logic [31:0] data;
    logic [3:0]  mask;
    int unsigned idle;
  } bank_cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] data;
    logic [1:0]  chan;
    err_t        err;
  } bank_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = '0;
  logic [1:0]  in_fifo_index = '0;
  logic [31:0] in_write_data = '0;
  logic [3:0]  in_channel_mask = '0;
  logic        out_strobe;
  logic [1:0]  out_result_kind;
  logic [31:0] out_read_data;
  logic [1:0]  out_granted_channel;
  logic [2:0]  out_error_code;

  bank_cmd_t   cmd_q[$];
  bank_reply_t bank_replies_q[$];
  int unsigned mismatches = 0;

  logic [31:0] bank_words [CHANS][DEPTH] = '{default: '0};
  logic [1:0]  bank_head [CHANS] = '{default: '0};
  logic [1:0]  bank_tail [CHANS] = '{default: '0};
  logic [2:0]  bank_fill [CHANS] = '{default: '0};
  logic [1:0]  last_grant = '0;
  logic [3:0]  pend_mask = '0;

  bank_cmd_t   next_cmd;
  bit          have_next = 1'b0;
  int unsigned idle_left = 0;

  input_fifo_bank_select_ready i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_fifo_index       (in_fifo_index),
    .in_write_data       (in_write_data),
    .in_channel_mask     (in_channel_mask),
    .out_strobe          (out_strobe),
    .out_result_kind     (out_result_kind),
    .out_read_data       (out_read_data),
    .out_granted_channel (out_granted_channel),
    .out_error_code      (out_error_code)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit grant_search(output logic [1:0] ch);
    logic [1:0] c;
    c = last_grant;
    ch = '0;
    if (pend_mask == '0) return 1'b0;
    for (int i = 0; i < CHANS; i++) begin
      c = c + 2'd1;
      if (bank_fill[c] != '0 && pend_mask[c]) begin
        last_grant = c;
        pend_mask = '0;
        ch = c;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit bank_step(input logic [1:0] op, input logic [1:0] idx,
                                   input logic [31:0] wd, input logic [3:0] msk,
                                   output bank_reply_t r);
    logic [1:0] ch;
    r.kind = RK_ERROR;
    r.data = '0;
    r.chan = '0;
    r.err  = ERR_NONE;
    case (op)
      CMD_WRITE: begin
        if (bank_fill[idx] == DEPTH) begin
          r.err = ERR_WRITE_FULL;
          return 1'b1;
        end
        bank_words[idx][bank_tail[idx]] = wd;
        bank_tail[idx] = bank_tail[idx] + 2'd1;
        bank_fill[idx] = bank_fill[idx] + 3'd1;
        if (grant_search(ch)) begin
          r.kind = RK_GRANT;
          r.chan = ch;
          return 1'b1;
        end
        return 1'b0;
      end
      CMD_READ: begin
        if (bank_fill[idx] == '0) begin
          r.err = ERR_READ_EMPTY;
          return 1'b1;
        end
        r.kind = RK_READ;
        r.data = bank_words[idx][bank_head[idx]];
        bank_head[idx] = bank_head[idx] + 2'd1;
        bank_fill[idx] = bank_fill[idx] - 3'd1;
        return 1'b1;
      end
      CMD_SELECT: begin
        if (msk == '0) begin
          r.err = ERR_ZERO_MASK;
          return 1'b1;
        end
        if (pend_mask != '0) begin
          r.err = ERR_PENDING;
          return 1'b1;
        end
        pend_mask = msk;
        if (grant_search(ch)) begin
          r.kind = RK_GRANT;
          r.chan = ch;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int unsigned pick_idle(bit burst);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (burst || p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_cmd(logic [1:0] op, logic [1:0] idx, logic [31:0] data,
                          logic [3:0] mask, bit burst);
    bank_cmd_t c;
    c.op   = op;
    c.idx  = idx;
    c.data = data;
    c.mask = mask;
    c.idle = pick_idle(burst);
    cmd_q = {cmd_q, c};
  endtask

  always @(posedge clk) begin
    bank_reply_t res;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start && bank_step(in_command, in_fifo_index, in_write_data, in_channel_mask, res))
        bank_replies_q = {bank_replies_q, res};
      if (!have_next && cmd_q.size() != 0) begin
        next_cmd = cmd_q.pop_front();
        have_next = 1'b1;
        idle_left = next_cmd.idle;
      end
      if (have_next && idle_left == 0) begin
        in_command      <= next_cmd.op;
        in_fifo_index   <= next_cmd.idx;
        in_write_data   <= next_cmd.data;
        in_channel_mask <= next_cmd.mask;
        start           <= 1'b1;
        have_next = 1'b0;
      end else begin
        start <= 1'b0;
        if (idle_left != 0) idle_left--;
      end
    end
  end

  always @(posedge clk) begin
    bank_reply_t want;
    if (rst_n && out_strobe) begin
      if (bank_replies_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result kind %0d data %h chan %0d err %0d", $time,
                 out_result_kind, out_read_data, out_granted_channel, out_error_code);
      end else begin
        want = bank_replies_q.pop_front();
        if (out_result_kind !== want.kind) begin
          mismatches++;
          $display("%0t: result_kind expected %0d actual %0d", $time, want.kind,
                   out_result_kind);
        end
        if (out_read_data !== want.data) begin
          mismatches++;
          $display("%0t: read_data expected %h actual %h", $time, want.data, out_read_data);
        end
        if (out_granted_channel !== want.chan) begin
          mismatches++;
          $display("%0t: granted_channel expected %0d actual %0d", $time, want.chan,
                   out_granted_channel);
        end
        if (out_error_code !== want.err) begin
          mismatches++;
          $display("%0t: error_code expected %0d actual %0d", $time, want.err,
                   out_error_code);
        end
      end
    end
  end

  initial begin
    int unsigned counted;
    int unsigned bias;
    int unsigned p;
    bit burst;
    logic [1:0] op;

    push_cmd(CMD_READ, 2'd0, '0, '0, 1'b0);
    push_cmd(CMD_SELECT, 2'd0, '0, 4'b0000, 1'b0);
    push_cmd(CMD_SELECT, 2'd0, '0, 4'b0010, 1'b0);
    push_cmd(CMD_SELECT, 2'd0, '0, 4'b0000, 1'b0);
    push_cmd(CMD_SELECT, 2'd0, '0, 4'b1000, 1'b0);
    push_cmd(CMD_READ, 2'd1, '0, '0, 1'b0);
    push_cmd(CMD_WRITE, 2'd0, 32'h0000_0000, 4'b1111, 1'b0);
    push_cmd(CMD_WRITE, 2'd1, 32'hFFFF_FFFF, '0, 1'b0);
    push_cmd(CMD_WRITE, 2'd1, 32'h8000_0001, '0, 1'b1);
    push_cmd(CMD_WRITE, 2'd1, 32'h7FFF_FFFE, '0, 1'b1);
    push_cmd(CMD_WRITE, 2'd1, 32'h1234_5678, '0, 1'b1);
    push_cmd(CMD_WRITE, 2'd1, 32'hDEAD_BEEF, '0, 1'b1);
    push_cmd(CMD_WRITE, 2'd3, 32'hA5A5_A5A5, '0, 1'b0);
    push_cmd(CMD_SELECT, 2'd0, '0, 4'b1111, 1'b0);
    push_cmd(CMD_SELECT, 2'd0, '0, 4'b1111, 1'b0);
    for (int i = 0; i < 5; i++) push_cmd(CMD_READ, 2'd1, '0, '0, 1'b1);
    push_cmd(CMD_READ, 2'd0, '0, '0, 1'b0);
    push_cmd(CMD_READ, 2'd3, '0, '0, 1'b0);
    push_cmd(CMD_UNUSED, 2'd3, 32'hFFFF_FFFF, 4'b1111, 1'b0);
    push_cmd(CMD_WRITE, 2'd2, 32'h5A5A_5A5A, '0, 1'b0);
    push_cmd(CMD_READ, 2'd2, '0, '0, 1'b1);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      bias = $urandom_range(0, 2);
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 40; i++) begin
        p = $urandom_range(0, 99);
        if (p < 2) op = CMD_UNUSED;
        else if (bias == 0) op = (p < 62) ? CMD_WRITE : (p < 77) ? CMD_READ : CMD_SELECT;
        else if (bias == 1) op = (p < 17) ? CMD_WRITE : (p < 77) ? CMD_READ : CMD_SELECT;
        else op = (p < 37) ? CMD_WRITE : (p < 72) ? CMD_READ : CMD_SELECT;
        push_cmd(op, 2'($urandom_range(0, CHANS - 1)), $urandom,
                 ($urandom_range(0, 9) == 0) ? 4'b0000 : 4'($urandom_range(1, 15)), burst);
        if (op != CMD_UNUSED) counted++;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() != 0 || have_next || start || bank_replies_q.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (bank_replies_q.size() != 0) begin
      mismatches += bank_replies_q.size();
      $display("%0t: %0d results expected, none arrived", $time, bank_replies_q.size());
    end
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ input_fifo_bank_select_ready.f @@
hw/rtl/ifbs_pkg.sv
hw/rtl/ifbs_ctrl.sv
hw/rtl/ifbs_datapath.sv
hw/rtl/input_fifo_bank_select_ready.sv
dv/tb_input_fifo_bank_select_ready.sv
